// ===== design/isrf_pkg.sv =====
// ----------------------------------------------------------------------------
// isrf_pkg: shared types and constants of the relabel filter
// Item kinds, field widths, counter limits and the layout of one map entry.
// ----------------------------------------------------------------------------
`default_nettype none

package isrf_pkg;

  // Item kinds carried on the input channel.
  typedef enum logic [1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_TERMINAL = 2'd1,
    KIND_EDGE     = 2'd2
  } kind_e;

  // Field widths.
  localparam int unsigned KindW   = 2;
  localparam int unsigned IdxW    = 12;
  localparam int unsigned TermW   = 13;
  localparam int unsigned CntW    = 32;
  localparam int unsigned WeightW = 64;

  // Epoch tag stored with each map entry. A tag of zero is never current,
  // so the sweep writes zero to mark every entry as unmapped.
  localparam int unsigned EpochW = 8;

  localparam logic [TermW-1:0]  TermMax    = '1;
  localparam logic [CntW-1:0]   CntMax     = '1;
  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [EpochW-1:0] EpochLast  = '1;

  // One entry of the vertex map: the epoch it was written in and its index.
  typedef struct packed {
    logic [EpochW-1:0] epoch;
    logic [IdxW-1:0]   idx;
  } map_entry_t;

endpackage

`default_nettype wire

// ===== design/induced_subgraph_relabel_filter.sv =====
// ----------------------------------------------------------------------------
// induced_subgraph_relabel_filter: vertex relabeling edge filter
// Maps terminal vertices to dense indices and passes on only the edges
// whose endpoints are both mapped, renamed and numbered.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one item per beat: a
//   clear, a terminal load or an edge. Output channel (out_valid_o /
//   out_stall_i) carries one beat per kept edge; other items give none.
//   A kept edge reaches the output through the map read and then the result
//   register. One item is taken every cycle while the output is not stalled
//   and no sweep runs; the dual-read map memory sets this.
//   A stalled output holds its beat; one more item still moves into the
//   check stage, after which in_stall_o rises until the result is taken.
//   Reset: the map is swept one entry per cycle with in_stall_o high.
//   Every 255th clear item since the last sweep starts another sweep.
//   Counters restart from zero after reset and after every clear.
// ----------------------------------------------------------------------------
`default_nettype none

module induced_subgraph_relabel_filter #(
  parameter int unsigned MAX_VERTICES = 4096
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire [isrf_pkg::KindW-1:0]         kind_i,
  input  wire [isrf_pkg::IdxW-1:0]          vertex_i,
  input  wire [isrf_pkg::IdxW-1:0]          other_vertex_i,
  input  wire [isrf_pkg::WeightW-1:0]       edge_weight_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [isrf_pkg::IdxW-1:0]         new_first_o,
  output logic [isrf_pkg::IdxW-1:0]         new_second_o,
  output logic [isrf_pkg::WeightW-1:0]      kept_weight_o,
  output logic [isrf_pkg::CntW-1:0]         kept_count_o
);

  localparam int unsigned AddrW = $clog2(MAX_VERTICES);

  logic                         accept;
  logic                         sweep_busy;
  logic                         stage_busy;
  logic [isrf_pkg::EpochW-1:0]  epoch;
  logic                         wr_en;
  logic [AddrW-1:0]             wr_addr;
  isrf_pkg::map_entry_t         wr_data;
  isrf_pkg::map_entry_t         rd_data_a;
  isrf_pkg::map_entry_t         rd_data_b;

  // Input handshake.
  assign in_stall_o = sweep_busy || stage_busy;
  assign accept     = in_valid_i && !in_stall_o;

  // Terminal numbering, epoch and sweep.
  isrf_map_ctrl #(
    .MaxVertices (MAX_VERTICES),
    .AddrW       (AddrW)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .vertex_i     (vertex_i),
    .sweep_busy_o (sweep_busy),
    .epoch_o      (epoch),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data)
  );

  // Vertex map, read at both endpoints on every accepted beat.
  isrf_map_ram #(
    .Depth (MAX_VERTICES),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (accept),
    .rd_addr_a_i (AddrW'(vertex_i)),
    .rd_addr_b_i (AddrW'(other_vertex_i)),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  // Edge check and result register.
  isrf_edge_stage #(
    .MaxVertices (MAX_VERTICES)
  ) u_edge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .kind_i         (kind_i),
    .vertex_i       (vertex_i),
    .other_vertex_i (other_vertex_i),
    .edge_weight_i  (edge_weight_i),
    .epoch_i        (epoch),
    .rd_data_a_i    (rd_data_a),
    .rd_data_b_i    (rd_data_b),
    .busy_o         (stage_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .new_first_o    (new_first_o),
    .new_second_o   (new_second_o),
    .kept_weight_o  (kept_weight_o),
    .kept_count_o   (kept_count_o)
  );

  // A kept edge always carries a count of at least one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kept_count_o != '0))
    else $error("kept edge with zero count");

  // A clear always moves the map to a new epoch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == isrf_pkg::KIND_CLEAR)) |=> (epoch != $past(epoch)))
    else $error("clear did not advance the epoch");

  // No terminal write may share the write port with the sweep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sweep_busy |-> (!accept && (wr_data.epoch == '0)))
    else $error("map write during sweep");

endmodule

`default_nettype wire

// ===== design/isrf_map_ram.sv =====
// ----------------------------------------------------------------------------
// isrf_map_ram: vertex map storage
// One write port and two registered read ports, read on an accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module isrf_map_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned AddrW = 12
) (
  input  wire                     clk_i,
  input  wire                     wr_en_i,
  input  wire [AddrW-1:0]         wr_addr_i,
  input  wire isrf_pkg::map_entry_t wr_data_i,
  input  wire                     rd_en_i,
  input  wire [AddrW-1:0]         rd_addr_a_i,
  input  wire [AddrW-1:0]         rd_addr_b_i,
  output isrf_pkg::map_entry_t    rd_data_a_o,
  output isrf_pkg::map_entry_t    rd_data_b_o
);

  isrf_pkg::map_entry_t mem_q [Depth];
  isrf_pkg::map_entry_t rd_a_q;
  isrf_pkg::map_entry_t rd_b_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Two read ports; data is held until the next accepted beat.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_a_q <= mem_q[rd_addr_a_i];
      rd_b_q <= mem_q[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule

`default_nettype wire

// ===== design/isrf_map_ctrl.sv =====
// ----------------------------------------------------------------------------
// isrf_map_ctrl: map write control
// Terminal numbering, the current epoch, and the sweep that invalidates
// every map entry after reset and when the epoch tag runs out.
// ----------------------------------------------------------------------------
`default_nettype none

module isrf_map_ctrl #(
  parameter int unsigned MaxVertices = 4096,
  parameter int unsigned AddrW       = 12
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                accept_i,
  input  wire [isrf_pkg::KindW-1:0]          kind_i,
  input  wire [isrf_pkg::IdxW-1:0]           vertex_i,
  output logic                               sweep_busy_o,
  output logic [isrf_pkg::EpochW-1:0]        epoch_o,
  output logic                               wr_en_o,
  output logic [AddrW-1:0]                   wr_addr_o,
  output isrf_pkg::map_entry_t               wr_data_o
);

  logic                         sweep_q, sweep_d;
  logic [AddrW-1:0]             sweep_addr_q, sweep_addr_d;
  logic [isrf_pkg::EpochW-1:0]  epoch_q, epoch_d;
  logic [isrf_pkg::TermW-1:0]   term_q, term_d;
  logic                         in_range;

  assign in_range = 32'(vertex_i) < 32'(MaxVertices);

  // Write port: the sweep owns it while running, otherwise terminal loads.
  always_comb begin
    wr_en_o   = sweep_q || (accept_i && (kind_i == isrf_pkg::KIND_TERMINAL) && in_range);
    wr_addr_o = sweep_q ? sweep_addr_q : AddrW'(vertex_i);
    if (sweep_q) begin
      wr_data_o = '{epoch: '0, idx: '0};
    end else begin
      wr_data_o = '{epoch: epoch_q, idx: term_q[isrf_pkg::IdxW-1:0]};
    end
  end

  // Next state of the counters and the sweep.
  always_comb begin
    sweep_d      = sweep_q;
    sweep_addr_d = sweep_addr_q;
    epoch_d      = epoch_q;
    term_d       = term_q;
    if (sweep_q) begin
      sweep_addr_d = sweep_addr_q + AddrW'(1);
      if (sweep_addr_q == AddrW'(MaxVertices - 1)) begin
        sweep_d      = 1'b0;
        sweep_addr_d = '0;
      end
    end else if (accept_i) begin
      case (kind_i)
        isrf_pkg::KIND_CLEAR: begin
          term_d = '0;
          if (epoch_q == isrf_pkg::EpochLast) begin
            epoch_d = isrf_pkg::EpochFirst;
            sweep_d = 1'b1;
          end else begin
            epoch_d = epoch_q + isrf_pkg::EpochW'(1);
          end
        end
        isrf_pkg::KIND_TERMINAL: begin
          if (term_q != isrf_pkg::TermMax) begin
            term_d = term_q + isrf_pkg::TermW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q      <= 1'b1;
      sweep_addr_q <= '0;
      epoch_q      <= isrf_pkg::EpochFirst;
      term_q       <= '0;
    end else begin
      sweep_q      <= sweep_d;
      sweep_addr_q <= sweep_addr_d;
      epoch_q      <= epoch_d;
      term_q       <= term_d;
    end
  end

  assign sweep_busy_o = sweep_q;
  assign epoch_o      = epoch_q;

endmodule

`default_nettype wire

// ===== design/isrf_edge_stage.sv =====
// ----------------------------------------------------------------------------
// isrf_edge_stage: edge check and result register
// Holds the accepted item beside the map read data, decides whether an
// edge is kept, counts kept edges and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module isrf_edge_stage #(
  parameter int unsigned MaxVertices = 4096
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                accept_i,
  input  wire [isrf_pkg::KindW-1:0]          kind_i,
  input  wire [isrf_pkg::IdxW-1:0]           vertex_i,
  input  wire [isrf_pkg::IdxW-1:0]           other_vertex_i,
  input  wire [isrf_pkg::WeightW-1:0]        edge_weight_i,
  input  wire [isrf_pkg::EpochW-1:0]         epoch_i,
  input  wire isrf_pkg::map_entry_t          rd_data_a_i,
  input  wire isrf_pkg::map_entry_t          rd_data_b_i,
  output logic                               busy_o,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [isrf_pkg::IdxW-1:0]          new_first_o,
  output logic [isrf_pkg::IdxW-1:0]          new_second_o,
  output logic [isrf_pkg::WeightW-1:0]       kept_weight_o,
  output logic [isrf_pkg::CntW-1:0]          kept_count_o
);

  typedef struct packed {
    logic [isrf_pkg::KindW-1:0]   kind;
    logic [isrf_pkg::WeightW-1:0] weight;
    logic [isrf_pkg::EpochW-1:0]  epoch;
    logic                         a_ok;
    logic                         b_ok;
  } stage_t;

  logic                          s1_valid_q, s1_valid_d;
  stage_t                        s1_q;
  logic                          out_valid_q, out_valid_d;
  logic [isrf_pkg::CntW-1:0]     edge_cnt_q, edge_cnt_d;
  logic [isrf_pkg::CntW-1:0]     edge_cnt_inc;
  logic [isrf_pkg::IdxW-1:0]     first_q;
  logic [isrf_pkg::IdxW-1:0]     second_q;
  logic [isrf_pkg::WeightW-1:0]  weight_q;
  logic [isrf_pkg::CntW-1:0]     count_q;
  logic                          out_ready;
  logic                          hit_a;
  logic                          hit_b;
  logic                          kept;

  // The output slot is free when empty or being taken this cycle.
  assign out_ready = !out_valid_q || !out_stall_i;
  assign busy_o    = s1_valid_q && !out_ready;

  // An endpoint is mapped when in range and written in the current epoch.
  assign hit_a = s1_q.a_ok && (rd_data_a_i.epoch == s1_q.epoch);
  assign hit_b = s1_q.b_ok && (rd_data_b_i.epoch == s1_q.epoch);
  assign kept  = s1_valid_q && (s1_q.kind == isrf_pkg::KIND_EDGE) && hit_a && hit_b;

  assign edge_cnt_inc = (edge_cnt_q == isrf_pkg::CntMax) ?
                        edge_cnt_q : edge_cnt_q + isrf_pkg::CntW'(1);

  // Control next state: stage occupancy, result valid and kept-edge count.
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    edge_cnt_d  = edge_cnt_q;
    if (out_ready) begin
      s1_valid_d  = 1'b0;
      out_valid_d = kept;
      if (s1_valid_q && (s1_q.kind == isrf_pkg::KIND_CLEAR)) begin
        edge_cnt_d = '0;
      end else if (kept) begin
        edge_cnt_d = edge_cnt_inc;
      end
    end
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      edge_cnt_q  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      edge_cnt_q  <= edge_cnt_d;
    end
  end

  // Stage payload, loaded on an accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q.kind   <= kind_i;
      s1_q.weight <= edge_weight_i;
      s1_q.epoch  <= epoch_i;
      s1_q.a_ok   <= 32'(vertex_i) < 32'(MaxVertices);
      s1_q.b_ok   <= 32'(other_vertex_i) < 32'(MaxVertices);
    end
  end

  // Result payload, loaded when a kept edge moves into the output slot.
  always_ff @(posedge clk_i) begin
    if (out_ready && kept) begin
      first_q  <= rd_data_a_i.idx;
      second_q <= rd_data_b_i.idx;
      weight_q <= s1_q.weight;
      count_q  <= edge_cnt_inc;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign new_first_o   = first_q;
  assign new_second_o  = second_q;
  assign kept_weight_o = weight_q;
  assign kept_count_o  = count_q;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the induced subgraph relabel filter
// Drives clears, terminal loads, edges and unused kinds with random idling
// and stalling on both channels. A scoreboard keeps its own vertex map and
// counters, predicts each kept edge and compares every output beat field by
// field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned                   NumVertices = 4096;
  localparam logic [isrf_pkg::KindW-1:0]    KindUnused  = 2'd3;
  localparam int unsigned                   RandomItems = 650;
  localparam int unsigned                   BulkLoads   = 200;
  localparam int unsigned                   HoldCycles  = 300;
  localparam int unsigned                   StuckLimit  = 20000;
  localparam int unsigned                   IdlePct     = 16;

  // One kept edge as it should leave the block.
  typedef struct packed {
    logic [isrf_pkg::IdxW-1:0]    first;
    logic [isrf_pkg::IdxW-1:0]    second;
    logic [isrf_pkg::WeightW-1:0] weight;
    logic [isrf_pkg::CntW-1:0]    count;
  } kept_edge_t;

  // Vertex map predictor and queue of edges still to come out.
  class relabel_scoreboard;
    logic [isrf_pkg::IdxW-1:0]  index_of [NumVertices];
    bit [NumVertices-1:0]       mapped;
    logic [isrf_pkg::TermW-1:0] term_count;
    logic [isrf_pkg::CntW-1:0]  kept_total;
    kept_edge_t                 kept_edges [$];
    int unsigned                error_count;

    function new();
      mapped      = '0;
      term_count  = '0;
      kept_total  = '0;
      error_count = 0;
    endfunction

    task report(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      error_count++;
    endtask

    // Update the map for one accepted input beat and queue any kept edge.
    function void note_item(input logic [isrf_pkg::KindW-1:0] kind,
                            input logic [isrf_pkg::IdxW-1:0] a,
                            input logic [isrf_pkg::IdxW-1:0] b,
                            input logic [isrf_pkg::WeightW-1:0] w);
      kept_edge_t e;
      case (kind)
        isrf_pkg::KIND_CLEAR: begin
          mapped     = '0;
          term_count = '0;
          kept_total = '0;
        end
        isrf_pkg::KIND_TERMINAL: begin
          index_of[a] = term_count[isrf_pkg::IdxW-1:0];
          mapped[a]   = 1'b1;
          if (term_count != isrf_pkg::TermMax) term_count++;
        end
        isrf_pkg::KIND_EDGE: begin
          if (mapped[a] && mapped[b]) begin
            if (kept_total != isrf_pkg::CntMax) kept_total++;
            e.first  = index_of[a];
            e.second = index_of[b];
            e.weight = w;
            e.count  = kept_total;
            kept_edges.push_back(e);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one output beat with the oldest queued edge.
    task check_result(input kept_edge_t got);
      kept_edge_t want;
      if (kept_edges.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
      end else begin
        want = kept_edges.pop_front();
        if (got.first !== want.first)
          report($sformatf("new_first %h, want %h", got.first, want.first));
        if (got.second !== want.second)
          report($sformatf("new_second %h, want %h", got.second, want.second));
        if (got.weight !== want.weight)
          report($sformatf("kept_weight %h, want %h", got.weight, want.weight));
        if (got.count !== want.count)
          report($sformatf("kept_count %0d, want %0d", got.count, want.count));
      end
    endtask

    function int unsigned pending();
      return kept_edges.size();
    endfunction

    task flag_leftovers();
      while (kept_edges.size() != 0) begin
        report($sformatf("edge never came out: %h", kept_edges.pop_front()));
      end
    endtask
  endclass

  logic                         clk_i        = 1'b0;
  logic                         rst_ni       = 1'b0;
  logic                         in_valid     = 1'b0;
  logic [isrf_pkg::KindW-1:0]   kind         = '0;
  logic [isrf_pkg::IdxW-1:0]    vertex       = '0;
  logic [isrf_pkg::IdxW-1:0]    other_vertex = '0;
  logic [isrf_pkg::WeightW-1:0] edge_weight  = '0;
  logic                         out_stall    = 1'b0;
  logic                         in_stall;
  logic                         out_valid;
  logic [isrf_pkg::IdxW-1:0]    new_first;
  logic [isrf_pkg::IdxW-1:0]    new_second;
  logic [isrf_pkg::WeightW-1:0] kept_weight;
  logic [isrf_pkg::CntW-1:0]    kept_count;

  bit                           calm     = 1'b0;
  bit                           hold_req = 1'b0;
  int unsigned                  items_sent = 0;
  int unsigned                  stuck_cycles = 0;
  logic [isrf_pkg::IdxW-1:0]    loaded [$];
  relabel_scoreboard            sb = new();

  induced_subgraph_relabel_filter #(
    .MAX_VERTICES(NumVertices)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .kind_i        (kind),
    .vertex_i      (vertex),
    .other_vertex_i(other_vertex),
    .edge_weight_i (edge_weight),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .new_first_o   (new_first),
    .new_second_o  (new_second),
    .kept_weight_o (kept_weight),
    .kept_count_o  (kept_count)
  );

  always #2 clk_i = ~clk_i;

  // Offer one beat, wait until it is taken, then idle now and then.
  task automatic send(input logic [isrf_pkg::KindW-1:0] k,
                      input logic [isrf_pkg::IdxW-1:0] a,
                      input logic [isrf_pkg::IdxW-1:0] b,
                      input logic [isrf_pkg::WeightW-1:0] w);
    kind         <= k;
    vertex       <= a;
    other_vertex <= b;
    edge_weight  <= w;
    in_valid     <= 1'b1;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    sb.note_item(k, a, b, w);
    if (k != KindUnused) items_sent++;
    if (!calm && $urandom_range(0, 99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  function automatic logic [isrf_pkg::WeightW-1:0] rand_weight();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [isrf_pkg::IdxW-1:0] pick_vertex(input int unsigned hit_pct);
    if (loaded.size() != 0 && $urandom_range(0, 99) < hit_pct)
      return loaded[$urandom_range(0, loaded.size() - 1)];
    return isrf_pkg::IdxW'($urandom);
  endfunction

  task automatic clear_map();
    send(isrf_pkg::KIND_CLEAR, isrf_pkg::IdxW'($urandom), isrf_pkg::IdxW'($urandom),
         rand_weight());
    loaded.delete();
  endtask

  task automatic load_terminals(input int unsigned n, input int unsigned pool_pct);
    logic [isrf_pkg::IdxW-1:0] v;
    repeat (n) begin
      v = ($urandom_range(0, 99) < pool_pct) ? isrf_pkg::IdxW'($urandom_range(0, 31))
                                             : isrf_pkg::IdxW'($urandom);
      send(isrf_pkg::KIND_TERMINAL, v, isrf_pkg::IdxW'($urandom), rand_weight());
      loaded.push_back(v);
    end
  endtask

  task automatic send_edges(input int unsigned n, input int unsigned hit_pct);
    repeat (n)
      send(isrf_pkg::KIND_EDGE, pick_vertex(hit_pct), pick_vertex(hit_pct), rand_weight());
  endtask

  // Stop offering beats until every queued edge has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Output side: stall at random, or hold off for a long stretch on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles - 1) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < IdlePct);
      end
    end
  end

  // Check every output beat taken at this edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && !out_stall)
      sb.check_result(kept_edge_t'{new_first, new_second, kept_weight, kept_count});
  end

  // Watchdog: end the run if no beat moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("testbench: errors");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned burst;
    int unsigned start;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: edges on an empty map, extremes, duplicates, self loop.
    send(isrf_pkg::KIND_EDGE, 12'h000, 12'hFFF, '1);
    send(isrf_pkg::KIND_TERMINAL, 12'h000, 12'hFFF, '0);
    send(isrf_pkg::KIND_TERMINAL, 12'hFFF, 12'h000, '1);
    send(isrf_pkg::KIND_TERMINAL, 12'hAAA, 12'h555, '0);
    send(isrf_pkg::KIND_TERMINAL, 12'h000, 12'h000, '0);
    send(isrf_pkg::KIND_EDGE, 12'h000, 12'hFFF, '1);
    send(isrf_pkg::KIND_EDGE, 12'hFFF, 12'h000, '0);
    send(isrf_pkg::KIND_EDGE, 12'h000, 12'h000, 64'h5555_5555_5555_5555);
    send(isrf_pkg::KIND_EDGE, 12'hAAA, 12'hFFF, 64'hAAAA_AAAA_AAAA_AAAA);
    send(isrf_pkg::KIND_EDGE, 12'h555, 12'h000, '1);
    send(isrf_pkg::KIND_EDGE, 12'h000, 12'h555, '1);
    send(KindUnused, 12'h000, 12'hFFF, '1);
    send(KindUnused, 12'hFFF, 12'hAAA, '0);
    send(isrf_pkg::KIND_EDGE, 12'h000, 12'hFFF, '0);
    send(isrf_pkg::KIND_CLEAR, 12'hFFF, 12'hFFF, '1);
    send(isrf_pkg::KIND_EDGE, 12'h000, 12'hFFF, '1);
    send(isrf_pkg::KIND_TERMINAL, 12'h555, 12'hFFF, '1);
    send(isrf_pkg::KIND_TERMINAL, 12'h2AA, 12'h000, '1);
    send(isrf_pkg::KIND_EDGE, 12'h555, 12'h2AA, 64'hAAAA_AAAA_AAAA_AAAA);
    send(isrf_pkg::KIND_EDGE, 12'h2AA, 12'h555, 64'h5555_5555_5555_5555);

    // A long run of loads over the whole id range, then edges among them.
    clear_map();
    load_terminals(BulkLoads, 0);
    send_edges(60, 100);
    send(isrf_pkg::KIND_TERMINAL, 12'h123, 12'h000, '0);
    send(isrf_pkg::KIND_EDGE, 12'h123, 12'h123, '1);
    clear_map();

    // Random bursts: loads followed by edges mostly on mapped vertices.
    start = items_sent;
    burst = 0;
    while (items_sent - start < RandomItems) begin
      calm = (burst >= 24 && burst < 34);
      if (burst == 10) hold_req = 1'b1;
      if (burst == 18) wait_drained();
      if ($urandom_range(0, 99) < 6) clear_map();
      load_terminals($urandom_range(1, 12), 50);
      send_edges($urandom_range(1, 16), 85);
      if ($urandom_range(0, 99) < 5)
        send(KindUnused, isrf_pkg::IdxW'($urandom), isrf_pkg::IdxW'($urandom),
             rand_weight());
      burst++;
    end
    calm = 1'b0;

    // Let the last edges out, then allow for the pipeline latency.
    wait_drained();
    repeat (8) @(posedge clk_i);
    sb.flag_leftovers();
    if (sb.error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
